@@ src/bitmap_slot_allocator_core_macros.svh @@
// Assertion macros for the bitmap slot allocator checker.
// Each macro expands to one labeled concurrent assertion clocked on i_clk.
`ifndef BITMAP_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bitmap slot allocator check failed");

// Next-cycle implication, disabled while reset is asserted
`define BSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bitmap slot allocator check failed");

`endif

@@ src/bsa_pkg.sv @@
// Shared types and constants of the bitmap slot allocator.
// Used by bsa_map, the top level and the checker; no dependencies.
`default_nettype none

package bsa_pkg;

    localparam int ACTIVE_W = 9;
    localparam int SLOT_W   = 8;
    localparam int OP_W     = 3;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC  = 3'd1;
    localparam logic [OP_W-1:0] OP_ASSIGN = 3'd2;
    localparam logic [OP_W-1:0] OP_SAMPLE = 3'd3;
    localparam logic [OP_W-1:0] OP_VACANT = 3'd4;

    // Register index of active_slots (address bit 2 of the APB port)
    localparam logic CFG_ACTIVE_SLOTS = 1'b0;
    localparam logic [ACTIVE_W-1:0] ACTIVE_SLOTS_RST = 9'd256;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [SLOT_W-1:0] slot_index;
        logic              write_value;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] result_index;
        logic              success;
        logic              bit_value;
    } t_out_item;

    // Request from the handshake stage to the map
    typedef struct packed {
        logic                advance;
        t_in_item            item;
        logic [ACTIVE_W-1:0] active_slots;
    } t_map_req;

endpackage

`default_nettype wire

@@ src/bsa_find_zero.sv @@
// Two-level priority encoder: lowest zero bit of the occupancy map.
// Standalone; no package dependency.
`default_nettype none

module bsa_find_zero #(
    parameter int MAX_SLOTS = 256
) (
    input  wire logic [MAX_SLOTS-1:0]         i_map,
    output logic                              o_found,
    output logic [$clog2(MAX_SLOTS)-1:0]      o_index
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int PAD_N = 2 ** IDX_W;
    localparam int LO_W  = IDX_W / 2;
    localparam int HI_W  = IDX_W - LO_W;
    localparam int GRP_S = 2 ** LO_W;
    localparam int GRP_N = 2 ** HI_W;

    logic [PAD_N-1:0] padded;
    logic [GRP_N-1:0] grp_free;
    logic [HI_W-1:0]  grp_sel;
    logic [GRP_S-1:0] grp_word;
    logic [LO_W-1:0]  bit_sel;

    // Pad unused slots as occupied so they are never chosen
    assign padded = {{(PAD_N - MAX_SLOTS){1'b1}}, i_map};

    always_comb begin
        for (int g = 0; g < GRP_N; g++) begin
            grp_free[g] = ~&padded[g*GRP_S +: GRP_S];
        end
    end

    always_comb begin
        grp_sel = '0;
        for (int g = GRP_N - 1; g >= 0; g--) begin
            if (grp_free[g]) begin
                grp_sel = HI_W'(g);
            end
        end
    end

    assign grp_word = padded[grp_sel*GRP_S +: GRP_S];

    always_comb begin
        bit_sel = '0;
        for (int b = GRP_S - 1; b >= 0; b--) begin
            if (!grp_word[b]) begin
                bit_sel = LO_W'(b);
            end
        end
    end

    assign o_found = |grp_free;
    assign o_index = {grp_sel, bit_sel};

endmodule

`default_nettype wire

@@ src/bsa_map.sv @@
// Occupancy map register and the single-pass operation logic.
// Depends on bsa_pkg and bsa_find_zero.
`default_nettype none

module bsa_map #(
    parameter int MAX_SLOTS = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bsa_pkg::t_map_req  i_req,
    output bsa_pkg::t_out_item      o_result
);

    import bsa_pkg::*;

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CMP_W = ((IDX_W > ACTIVE_W) ? IDX_W : ACTIVE_W) + 1;

    logic [MAX_SLOTS-1:0] r_map;
    logic [MAX_SLOTS-1:0] n_map;
    logic                 found;
    logic [IDX_W-1:0]     found_idx;
    logic [CMP_W-1:0]     found_ext;
    logic [CMP_W-1:0]     active_ext;
    logic [CMP_W-1:0]     slot_ext;
    logic [IDX_W-1:0]     slot_addr;
    logic                 slot_ok;
    logic                 search_ok;

    bsa_find_zero #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_find_zero (
        .i_map   (r_map),
        .o_found (found),
        .o_index (found_idx)
    );

    assign found_ext  = CMP_W'(found_idx);
    assign active_ext = CMP_W'(i_req.active_slots);
    assign slot_ext   = CMP_W'(i_req.item.slot_index);
    assign slot_addr  = slot_ext[IDX_W-1:0];
    // Lowest free slot overall; it counts only if below the active count
    assign search_ok  = found && (found_ext < active_ext);
    assign slot_ok    = (slot_ext < active_ext) && (slot_ext < CMP_W'(MAX_SLOTS));

    always_comb begin
        n_map    = r_map;
        o_result = '0;
        case (i_req.item.operation) inside
            OP_CLEAR: begin
                n_map            = '0;
                o_result.success = 1'b1;
            end
            OP_ALLOC, OP_VACANT: begin
                if (search_ok) begin
                    o_result.success      = 1'b1;
                    o_result.result_index = found_ext[SLOT_W-1:0];
                    if (i_req.item.operation == OP_ALLOC) begin
                        n_map[found_idx] = 1'b1;
                    end
                end
            end
            OP_ASSIGN: begin
                if (slot_ok) begin
                    o_result.success   = 1'b1;
                    o_result.bit_value = r_map[slot_addr];
                    n_map[slot_addr]   = i_req.item.write_value;
                end
            end
            OP_SAMPLE: begin
                if (slot_ok) begin
                    o_result.success   = 1'b1;
                    o_result.bit_value = r_map[slot_addr];
                end
            end
            default: begin
                n_map = r_map;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else if (i_req.advance) begin
            r_map <= n_map;
        end
    end

endmodule

`default_nettype wire

@@ src/bitmap_slot_allocator_core.sv @@
// Top level of the bitmap slot allocator: handshake stages, config register.
// Depends on bsa_pkg and bsa_map (which uses bsa_find_zero).
//
// Usage:
//   Input channel (i_in_valid / i_in_data / o_in_stall) carries one operation
//   per transaction: clear all, allocate, assign, sample or find vacant.
//   Output channel (o_out_valid / o_out_data / i_out_stall) returns exactly
//   one result transaction per input transaction, in order.
//   The APB port holds one register, active_slots, at byte address 0.
//   Write it only while no transaction is in flight.
// Timing:
//   A transaction is first registered in the input stage, then executed against
//   the map in one pass (priority encoder plus bit update) as it moves into the
//   result stage, whose register drives the output. Throughput is one
//   transaction per cycle while the receiver does not stall, set by the
//   combinational encoder over the flip-flop map.
// Reset:
//   Synchronous, active low. The map returns to all free, active_slots to
//   256, and both stages empty.
// Stall:
//   While the receiver stalls a held result, the input stage holds its item
//   and o_in_stall rises once that stage is occupied; no result is dropped.
`default_nettype none

module bitmap_slot_allocator_core #(
    parameter int MAX_SLOTS = 256
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire bsa_pkg::t_in_item   i_in_data,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output bsa_pkg::t_out_item       o_out_data,
    input  wire logic                i_out_stall,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    import bsa_pkg::*;

    // Input stage
    logic                r_s1_valid;
    t_in_item            r_s1_item;
    // Result stage
    logic                r_out_valid;
    t_out_item           r_out_item;
    // Configuration
    logic [ACTIVE_W-1:0] r_active_slots;

    logic                advance;
    logic                in_take;
    logic                cfg_wr;
    t_map_req            map_req;
    t_out_item           map_result;

    // Move the held item into the result stage when that stage frees up
    assign advance = r_s1_valid && (!r_out_valid || !i_out_stall);
    // Take a new transaction when the input stage is empty or drains now
    assign in_take = i_in_valid && (!r_s1_valid || advance);

    assign o_in_stall  = r_s1_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    assign map_req.advance      = advance;
    assign map_req.item         = r_s1_item;
    assign map_req.active_slots = r_active_slots;

    bsa_map #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (map_req),
        .o_result (map_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= map_result;
        end
    end

    // APB: zero-wait-state, byte address bit 2 selects the register,
    // byte offset bits are ignored on writes; reads need them zero
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_ACTIVE_SLOTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots <= ACTIVE_SLOTS_RST;
        end else if (cfg_wr) begin
            r_active_slots <= pwdata[ACTIVE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == CFG_ACTIVE_SLOTS && paddr[1:0] == 2'b00) begin
            prdata = 32'(r_active_slots);
        end
    end

endmodule

`default_nettype wire

@@ src/bsa_checker.sv @@
// Port-level checker for bitmap_slot_allocator_core, attached by bind.
// Depends on bsa_pkg and bitmap_slot_allocator_core_macros.svh.
`default_nettype none
`include "bitmap_slot_allocator_core_macros.svh"

module bsa_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                o_in_stall,
    input  wire logic                o_out_valid,
    input  wire bsa_pkg::t_out_item  o_out_data,
    input  wire logic                i_out_stall
);

    // Input side only backs up behind a blocked result
    `BSA_ASSERT_NOW(a_stall_only_when_blocked, o_in_stall, o_out_valid && i_out_stall)
    // A bit is reported only by a successful assign or sample
    `BSA_ASSERT_NOW(a_bit_needs_success, o_out_valid && o_out_data.bit_value, o_out_data.success)
    // A nonzero slot index is reported only by a successful search
    `BSA_ASSERT_NOW(a_index_needs_success, o_out_valid && (o_out_data.result_index != 8'd0), o_out_data.success)
    // Hold a stalled result
    `BSA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for bitmap_slot_allocator_core: directed script, then random traffic.
// Depends on bsa_pkg and the RTL only; expected results come from an in-file map predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsa_pkg::*;

    localparam int MAP_DEPTH   = 256;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;
    // Operation codes the block does not define; they must return all zeros.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    // Idle patterns, rotated every IDLE_SPAN transactions
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;
    localparam int IDLE_SPAN = 40;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    t_in_item            i_in_data = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_out_item           o_out_data;
    logic                i_out_stall = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    bitmap_slot_allocator_core #(
        .MAX_SLOTS(MAP_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: one bit per slot (1 = used) and the active slot count
    bit [MAP_DEPTH-1:0]  slot_map = '0;
    logic [ACTIVE_W-1:0] slot_count = ACTIVE_SLOTS_RST;

    t_out_item pending_results[$];
    int        fail_count = 0;
    int        sent_count = 0;
    int        idle_mode = IDLE_NONE;
    int        cycle_count = 0;

    // Directed script: either a register write or one transaction, with the
    // expected result typed in where it is obvious from the rules
    typedef struct packed {
        bit                  is_cfg;
        logic [ACTIVE_W-1:0] cfg_value;
        t_in_item            req;
        bit                  typed;
        t_out_item           want;
    } t_script_row;

    t_script_row script[$];

    // Counts above the map size behave as the full map
    function automatic int active_limit();
        return (slot_count > MAP_DEPTH) ? MAP_DEPTH : int'(slot_count);
    endfunction

    // Apply one operation to the predicted map and return its result
    function automatic t_out_item apply_request(input t_in_item req);
        t_out_item res;
        int lim;
        int k;
        res = '0;
        lim = active_limit();
        case (req.operation)
            OP_CLEAR: begin
                slot_map = '0;
                res.success = 1'b1;
            end
            OP_ALLOC, OP_VACANT: begin
                // Lowest free slot below the limit
                k = 0;
                while (k < lim && slot_map[k])
                    k++;
                if (k < lim) begin
                    if (req.operation == OP_ALLOC)
                        slot_map[k] = 1'b1;
                    res.result_index = k[SLOT_W-1:0];
                    res.success = 1'b1;
                end
            end
            OP_ASSIGN: begin
                if (int'(req.slot_index) < lim) begin
                    res.bit_value = slot_map[req.slot_index];
                    slot_map[req.slot_index] = req.write_value;
                    res.success = 1'b1;
                end
            end
            OP_SAMPLE: begin
                if (int'(req.slot_index) < lim) begin
                    res.bit_value = slot_map[req.slot_index];
                    res.success = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic add_op(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] idx,
                          input logic wval, input bit typed,
                          input logic [SLOT_W-1:0] ri, input logic ok, input logic bv);
        t_script_row row;
        row = '0;
        row.req.operation = op;
        row.req.slot_index = idx;
        row.req.write_value = wval;
        row.typed = typed;
        row.want.result_index = ri;
        row.want.success = ok;
        row.want.bit_value = bv;
        script.push_back(row);
    endtask

    task automatic add_cfg(input logic [ACTIVE_W-1:0] value);
        t_script_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.cfg_value = value;
        script.push_back(row);
    endtask

    // Random operation; fill_mode leans hard on allocate so the map fills up
    function automatic t_in_item random_request(input bit fill_mode);
        t_in_item req;
        int pick;
        int lim;
        lim = active_limit();
        pick = $urandom_range(0, 999);
        req.write_value = fill_mode ? ($urandom_range(0, 3) != 0)
                                    : 1'($urandom_range(0, 1));
        if (lim > 0 && $urandom_range(0, 99) < 85)
            req.slot_index = SLOT_W'($urandom_range(0, lim - 1));
        else
            req.slot_index = SLOT_W'($urandom_range(0, MAP_DEPTH - 1));
        if (fill_mode) begin
            if (pick < 3)        req.operation = OP_CLEAR;
            else if (pick < 800) req.operation = OP_ALLOC;
            else if (pick < 870) req.operation = OP_ASSIGN;
            else if (pick < 920) req.operation = OP_SAMPLE;
            else if (pick < 970) req.operation = OP_VACANT;
            else req.operation = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end else begin
            if (pick < 30)       req.operation = OP_CLEAR;
            else if (pick < 400) req.operation = OP_ALLOC;
            else if (pick < 600) req.operation = OP_ASSIGN;
            else if (pick < 750) req.operation = OP_SAMPLE;
            else if (pick < 930) req.operation = OP_VACANT;
            else req.operation = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        return req;
    endfunction

    // Offer one transaction; entered and left at a falling edge. Idle cycles
    // go in front of the transaction, and valid is assigned once per edge.
    task automatic push_request(input t_in_item req, input bit typed, input t_out_item want);
        t_out_item predicted;
        idle_mode = (sent_count / IDLE_SPAN) % 4;
        while ((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 83) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 23)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        // Hold the payload until the block takes it
        do
            @(posedge i_clk);
        while (o_in_stall);
        predicted = apply_request(req);
        pending_results.push_back(typed ? want : predicted);
        sent_count++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every result is back; the block is then idle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // APB write of active_slots followed by a read-back; entered at a falling edge
    task automatic write_slot_count(input logic [ACTIVE_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {CFG_ACTIVE_SLOTS, 2'b00};
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        slot_count = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        if (prdata[ACTIVE_W-1:0] !== value) begin
            $display("%0t: active_slots read-back expected %0d actual %0d",
                     $time, value, prdata[ACTIVE_W-1:0]);
            fail_count++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver stall pattern follows the same rotating idle mode
    always @(negedge i_clk) begin
        i_out_stall <= (idle_mode == IDLE_RECV && $urandom_range(0, 99) < 83) ||
                       (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 23);
    end

    // Compare every accepted result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction, actual %h", $time, o_out_data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.result_index !== want.result_index) begin
                    $display("%0t: result_index expected %0d actual %0d",
                             $time, want.result_index, o_out_data.result_index);
                    fail_count++;
                end
                if (o_out_data.success !== want.success) begin
                    $display("%0t: success expected %0d actual %0d",
                             $time, want.success, o_out_data.success);
                    fail_count++;
                end
                if (o_out_data.bit_value !== want.bit_value) begin
                    $display("%0t: bit_value expected %0d actual %0d",
                             $time, want.bit_value, o_out_data.bit_value);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: bound the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Random phases: active_slots value and length of each phase
    logic [ACTIVE_W-1:0] phase_count[8];
    int                  phase_items[8];

    initial begin
        // Reset state: full map active, all slots free
        add_op(OP_SAMPLE, 8'd0, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0);
        add_op(OP_SAMPLE, 8'd255, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0);
        add_op(OP_ALLOC, 8'd0, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0);
        add_op(OP_ALLOC, 8'd0, 1'b0, 1'b1, 8'd1, 1'b1, 1'b0);
        add_op(OP_VACANT, 8'd0, 1'b0, 1'b1, 8'd2, 1'b1, 1'b0);
        // Assign returns the old bit, top slot first
        add_op(OP_ASSIGN, 8'd255, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0);
        add_op(OP_ASSIGN, 8'd255, 1'b0, 1'b1, 8'd0, 1'b1, 1'b1);
        add_op(OP_SAMPLE, 8'd255, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_op(OP_ASSIGN, 8'd0, 1'b0, 1'b1, 8'd0, 1'b1, 1'b1);
        add_op(OP_VACANT, 8'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        // Undefined codes do nothing
        add_op(OP_UNUSED_LO, 8'd255, 1'b1, 1'b1, 8'd0, 1'b0, 1'b0);
        add_op(OP_UNUSED_HI, 8'd0, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0);
        add_op(OP_CLEAR, 8'd0, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0);
        // Two active slots: fill them, then hit full map and out-of-range index
        add_cfg(9'd2);
        add_op(OP_ALLOC, 8'd0, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0);
        add_op(OP_ALLOC, 8'd0, 1'b0, 1'b1, 8'd1, 1'b1, 1'b0);
        add_op(OP_ALLOC, 8'd0, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0);
        add_op(OP_VACANT, 8'd0, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0);
        add_op(OP_SAMPLE, 8'd2, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0);
        add_op(OP_ASSIGN, 8'd255, 1'b1, 1'b1, 8'd0, 1'b0, 1'b0);
        add_op(OP_SAMPLE, 8'd1, 1'b0, 1'b1, 8'd0, 1'b1, 1'b1);
        // Zero active slots: nothing in range, but clear still works
        add_cfg(9'd0);
        add_op(OP_VACANT, 8'd0, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0);
        add_op(OP_ASSIGN, 8'd0, 1'b1, 1'b1, 8'd0, 1'b0, 1'b0);
        add_op(OP_CLEAR, 8'd0, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0);
        // Count above the map size acts as the full map
        add_cfg(9'd511);
        add_op(OP_SAMPLE, 8'd1, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_op(OP_ALLOC, 8'd0, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0);
        add_op(OP_ASSIGN, 8'd255, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0);

        phase_count = '{9'd256, 9'd1, 9'd511, 9'd0, 9'd7, 9'd300, 9'd0, 9'd256};
        phase_items = '{320, 60, 100, 40, 80, 80, 100, 60};
        phase_count[6] = ACTIVE_W'($urandom_range(1, MAP_DEPTH));

        // Hold reset, then release it at a falling edge
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                drain_results();
                write_slot_count(script[i].cfg_value);
            end else begin
                push_request(script[i].req, script[i].typed, script[i].want);
            end
        end

        // Random part; the first phase runs alloc-heavy to reach the top slots
        for (int p = 0; p < 8; p++) begin
            drain_results();
            write_slot_count(phase_count[p]);
            for (int n = 0; n < phase_items[p]; n++)
                push_request(random_request(p == 0), 1'b0, '0);
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
